>>> hdl/hga_pkg.sv
package hga_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int SLOT_W = 16;
   localparam int HANDLE_W = 32;
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // free-slot search looks at one group of slots per cycle
   localparam int GROUP_W = 8;
   localparam int GROUP_SEL_W = $clog2(GROUP_W);
   localparam int GROUP_COUNT = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
   localparam int GRP_IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int PAD_W = GROUP_COUNT * GROUP_W;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [IDX_W-1:0] idx;
   } scan_res_type;

endpackage

>>> hdl/hga_ram.sv
module hga_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> hdl/hga_scan.sv
module hga_scan
   import hga_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SLOT_COUNT-1:0] busy,
   output scan_res_type          res
);

   logic                   running_ff, running_in;
   logic [GRP_IDX_W-1:0]   grp_ff, grp_in;
   logic [PAD_W-1:0]       free_pad;
   logic [GROUP_W-1:0]     bits;
   logic [GROUP_SEL_W-1:0] pe;
   logic                   any_free;
   logic                   last_grp;

   // slots past the end of the pool read as taken
   assign free_pad = PAD_W'(~busy);
   assign bits = free_pad[grp_ff*GROUP_W +: GROUP_W];
   assign any_free = |bits;
   assign last_grp = (grp_ff == GRP_IDX_W'(GROUP_COUNT - 1));

   always_comb begin
      pe = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pe = GROUP_SEL_W'(i);
         end
      end
   end

   always_comb begin
      res.done = running_ff && (any_free || last_grp);
      res.found = running_ff && any_free;
      res.idx = IDX_W'({grp_ff, pe});
      running_in = running_ff;
      grp_in = grp_ff;
      if (start) begin
         running_in = 1'b1;
         grp_in = '0;
      end else if (running_ff) begin
         if (res.done) begin
            running_in = 1'b0;
         end else begin
            grp_in = grp_ff + GRP_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
      grp_ff <= grp_in;
   end

endmodule

>>> hdl/generational_handle_allocator_unit.sv
// generational handle allocator
// hands out slots of a fixed pool as 32-bit handles: reuse count in the upper
// half, slot number plus 1 in the lower half.
// request channel (req_valid/req_stall): req_type 0 allocates the lowest free
// slot, 1 looks up req_handle_in, 2 releases it. one word is taken at a time;
// req_stall stays high from acceptance until the result is loaded.
// response channel (rsp_valid/rsp_stall): one word per request with status,
// handle and slot number; a held word stays unchanged while rsp_stall is high,
// and the next request can be accepted while it waits.
// order: lookup and release read the reuse count, evaluate it and then load the
// response (a handle that names no slot goes straight to the load); allocate
// first runs the free-slot search over groups of eight slots, all 64 for a full pool.
// an allocate reads the reuse count memory once, then writes it once; lookup
// and release only read it, and a handle that names no slot skips it.
// a result that cannot be loaded because the response is stalled waits in
// place. reset frees all slots and zeroes all reuse counts at once.
module generational_handle_allocator_unit
   import hga_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic [HANDLE_W-1:0] req_handle_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [SLOT_W-1:0]   rsp_slot_index
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            type_ff, type_in;
   logic [HANDLE_W-1:0]   hin_ff, hin_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [SLOT_COUNT-1:0] written_ff, written_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]   res_handle_ff, res_handle_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic                  req_take;
   logic                  scan_start;
   scan_res_type          scan_res;
   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_wdata;
   logic [SLOT_W-1:0]     ram_rdata;
   logic [SLOT_W-1:0]     count;
   logic [SLOT_W-1:0]     low;
   logic                  low_ok;
   logic                  match;
   logic                  out_free;

   hga_scan u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .busy  (busy_ff),
      .res   (scan_res)
   );

   hga_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOT_COUNT)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (ram_wdata),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign low = req_handle_in[SLOT_W-1:0];
   assign low_ok = (low != '0) && ({1'b0, low} <= (SLOT_W + 1)'(SLOT_COUNT));

   // a never-written entry holds the reset count of zero
   assign count = written_ff[idx_ff] ? ram_rdata : '0;
   // a live slot's handle carries the count from before the bump
   assign match = busy_ff[idx_ff] && (hin_ff[HANDLE_W-1:SLOT_W] == count - SLOT_W'(1));

   always_comb begin
      state_in = state_ff;
      type_in = type_ff;
      hin_in = hin_ff;
      idx_in = idx_ff;
      busy_in = busy_ff;
      written_in = written_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_slot_in = res_slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_slot_in = rsp_slot_ff;
      scan_start = 1'b0;
      ram_we = 1'b0;
      ram_wdata = count + SLOT_W'(1);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               type_in = req_type;
               hin_in = req_handle_in;
               idx_in = IDX_W'(low - SLOT_W'(1));
               res_status_in = ST_BAD;
               res_handle_in = '0;
               res_slot_in = '0;
               if (req_type == REQ_ALLOC) begin
                  scan_start = 1'b1;
                  state_in = S_SCAN;
               end else if ((req_type == REQ_LOOKUP || req_type == REQ_RELEASE) && low_ok) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (scan_res.done) begin
               if (scan_res.found) begin
                  idx_in = scan_res.idx;
                  state_in = S_READ;
               end else begin
                  res_status_in = ST_FULL;
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (type_ff == REQ_ALLOC) begin
               ram_we = 1'b1;
               busy_in[idx_ff] = 1'b1;
               written_in[idx_ff] = 1'b1;
               res_status_in = ST_OK;
               res_handle_in = {count, SLOT_W'(idx_ff) + SLOT_W'(1)};
               res_slot_in = SLOT_W'(idx_ff);
            end else if (match) begin
               if (type_ff == REQ_RELEASE) begin
                  busy_in[idx_ff] = 1'b0;
               end
               res_status_in = ST_OK;
               res_handle_in = hin_ff;
               res_slot_in = SLOT_W'(idx_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_slot_in = res_slot_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= '0;
         written_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         written_ff <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff <= type_in;
      hin_ff <= hin_in;
      idx_ff <= idx_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_slot_ff <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

>>> hdl/hga_checker.sv
module hga_checker
   import hga_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [1:0]          req_type,
   input logic [HANDLE_W-1:0] req_handle_in,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic [HANDLE_W-1:0] rsp_handle_out,
   input logic [SLOT_W-1:0]   rsp_slot_index
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_handle_out) && $stable(rsp_slot_index))
      else $error("response word changed while stalled");

   // failures carry no handle and no slot
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_handle_out == '0 && rsp_slot_index == '0)
      else $error("failed response carries a handle");

   // a good handle names its slot plus one
   a_ok_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK
         |-> rsp_handle_out[SLOT_W-1:0] == rsp_slot_index + SLOT_W'(1)
         && {1'b0, rsp_slot_index} < (SLOT_W + 1)'(SLOT_COUNT))
      else $error("handle and slot disagree");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_FULL || rsp_status == ST_BAD)
      else $error("unknown status code");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response word right after reset");

endmodule

bind generational_handle_allocator_unit hga_checker u_hga_checker (.*);
